[sv/ssfl_pkg.sv]
// ---------------------------------------------------------------------------
// Sorted symbol floor lookup package
// Shared widths, codes and state encoding for the symbol table block.
// ---------------------------------------------------------------------------
`default_nettype none

package ssfl_pkg;

  localparam int unsigned ADDR_W          = 64;
  localparam int unsigned SYM_ID_W        = 16;
  localparam int unsigned STATUS_W        = 2;
  localparam int unsigned TABLE_DEPTH_DEF = 4096;
  localparam int unsigned ID_WIDTH_DEF    = 16;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_LOOKUP = 1'b1
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_SHIFT,
    ST_WRITE,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

[sv/ssfl_if.sv]
// ---------------------------------------------------------------------------
// Sorted symbol floor lookup channels
// Request and response channels with a valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface ssfl_req_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [ssfl_pkg::ADDR_W-1:0]   sym_address;
  logic [ssfl_pkg::SYM_ID_W-1:0] sym_id;

  modport source (output valid, output kind, output sym_address, output sym_id,
                  input ready);
  modport sink   (input valid, input kind, input sym_address, input sym_id,
                  output ready);
endinterface

interface ssfl_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ssfl_pkg::STATUS_W-1:0] status;
  logic [ssfl_pkg::SYM_ID_W-1:0] found_id;
  logic [ssfl_pkg::ADDR_W-1:0]   found_start;

  modport source (output valid, output status, output found_id, output found_start,
                  input ready);
  modport sink   (input valid, input status, input found_id, input found_start,
                  output ready);
endinterface

`default_nettype wire

[sv/sorted_symbol_floor_lookup.sv]
// ---------------------------------------------------------------------------
// Sorted symbol floor lookup
// Symbol table kept in ascending start order in one synchronous memory;
// inserts shift larger entries up, lookups return the floor entry.
// ---------------------------------------------------------------------------
//
//  Channel  Direction  Payload                               Handshake
//  req_i    in         kind, sym_address, sym_id             valid/ready
//  rsp_o    out        status, found_id, found_start         valid/ready
//
// One request is processed at a time. A binary search over the n stored
// entries does each step as a memory read, then a compare. An insert then
// shifts the larger entries up, one entry per cycle through the single read
// and single write port of the table memory; a full-table insert skips the
// search and the shift. Reset clears the entry count and control state but
// not the table memory; no clearing pass is needed. The response register
// holds a finished result while the next request is accepted.
`default_nettype none

module sorted_symbol_floor_lookup #(
  parameter int unsigned TABLE_DEPTH = ssfl_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned ID_WIDTH    = ssfl_pkg::ID_WIDTH_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ssfl_req_if.sink    req_i,
  ssfl_rsp_if.source  rsp_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned DW = ssfl_pkg::ADDR_W + ID_WIDTH;
  localparam int unsigned AdrW = ssfl_pkg::ADDR_W;
  localparam int unsigned SidW = ssfl_pkg::SYM_ID_W;

  ssfl_pkg::state_e state_q, state_d;

  // Table memory: {id, start} per entry, one write and one registered read.
  logic [DW-1:0] mem_q [TABLE_DEPTH];
  logic [DW-1:0] rdata_q;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] mem_wr_addr;
  logic [DW-1:0] mem_wr_data;

  logic [CW-1:0]   count_q;
  logic [CW-1:0]   lo_q, hi_q, mid_q, sh_q;
  logic [CW-1:0]   mid;
  logic            kind_q;
  logic [AdrW-1:0] addr_q;
  logic [ID_WIDTH-1:0] id_q;
  logic [DW-1:0]   best_q;
  logic            full_q;
  logic            wr_pend_q;
  logic [AW-1:0]   wr_addr_q;

  logic            req_fire;
  logic            rsp_load;
  logic            table_full;
  logic            srch_go_hi;

  logic [SidW+ID_WIDTH-1:0] id_in_ext;
  logic [SidW+ID_WIDTH-1:0] id_out_ext;

  logic                              rsp_valid_q;
  logic [ssfl_pkg::STATUS_W-1:0]     rsp_status_q;
  logic [SidW-1:0]                   rsp_id_q;
  logic [AdrW-1:0]                   rsp_start_q;

  assign req_fire   = req_i.valid && req_i.ready;
  assign table_full = (count_q == CW'(TABLE_DEPTH));
  assign mid        = lo_q + ((hi_q - lo_q) >> 1);
  assign srch_go_hi = (rdata_q[AdrW-1:0] > addr_q);
  assign id_in_ext  = {{ID_WIDTH{1'b0}}, req_i.sym_id};
  assign id_out_ext = {{SidW{1'b0}}, best_q[DW-1:AdrW]};

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ssfl_pkg::ST_IDLE: begin
        if (req_fire) begin
          if (req_i.kind == ssfl_pkg::KIND_INSERT && table_full) begin
            state_d = ssfl_pkg::ST_DONE;
          end else begin
            state_d = ssfl_pkg::ST_SRCH_RD;
          end
        end
      end
      ssfl_pkg::ST_SRCH_RD: begin
        if (lo_q != hi_q) begin
          state_d = ssfl_pkg::ST_SRCH_CMP;
        end else if (kind_q == ssfl_pkg::KIND_LOOKUP) begin
          state_d = ssfl_pkg::ST_DONE;
        end else begin
          state_d = ssfl_pkg::ST_SHIFT;
        end
      end
      ssfl_pkg::ST_SRCH_CMP: state_d = ssfl_pkg::ST_SRCH_RD;
      ssfl_pkg::ST_SHIFT: begin
        if (sh_q == lo_q) begin
          state_d = ssfl_pkg::ST_WRITE;
        end
      end
      ssfl_pkg::ST_WRITE: state_d = ssfl_pkg::ST_DONE;
      ssfl_pkg::ST_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          state_d = ssfl_pkg::ST_IDLE;
        end
      end
      default: state_d = ssfl_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the controller: handshake, memory ports
  always_comb begin
    req_i.ready = 1'b0;
    rsp_load    = 1'b0;
    rd_addr     = mid[AW-1:0];
    mem_we      = 1'b0;
    mem_wr_addr = wr_addr_q;
    mem_wr_data = rdata_q;
    unique case (state_q)
      ssfl_pkg::ST_IDLE: req_i.ready = 1'b1;
      ssfl_pkg::ST_SHIFT: begin
        rd_addr = AW'(sh_q - 1'b1);
        mem_we  = wr_pend_q;
      end
      ssfl_pkg::ST_WRITE: begin
        mem_we      = 1'b1;
        mem_wr_addr = lo_q[AW-1:0];
        mem_wr_data = {id_q, addr_q};
      end
      ssfl_pkg::ST_DONE: rsp_load = !rsp_valid_q || rsp_o.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[rd_addr];
    if (mem_we) begin
      mem_q[mem_wr_addr] <= mem_wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ssfl_pkg::ST_IDLE;
      count_q   <= '0;
      wr_pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ssfl_pkg::ST_SRCH_RD) begin
        wr_pend_q <= 1'b0;
      end else if (state_q == ssfl_pkg::ST_SHIFT) begin
        wr_pend_q <= (sh_q != lo_q);
      end
      if (state_q == ssfl_pkg::ST_WRITE) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  // Search and shift datapath
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      kind_q <= req_i.kind;
      addr_q <= req_i.sym_address;
      id_q   <= id_in_ext[ID_WIDTH-1:0];
      full_q <= table_full;
      lo_q   <= '0;
      hi_q   <= count_q;
    end
    unique case (state_q)
      ssfl_pkg::ST_SRCH_RD: begin
        mid_q <= mid;
        sh_q  <= count_q;
      end
      ssfl_pkg::ST_SRCH_CMP: begin
        // Entries not above the query move the lower bound; the last such
        // entry is the floor.
        if (srch_go_hi) begin
          hi_q <= mid_q;
        end else begin
          lo_q   <= mid_q + 1'b1;
          best_q <= rdata_q;
        end
      end
      ssfl_pkg::ST_SHIFT: begin
        wr_addr_q <= sh_q[AW-1:0];
        if (sh_q != lo_q) begin
          sh_q <= sh_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      rsp_id_q    <= '0;
      rsp_start_q <= '0;
      if (kind_q == ssfl_pkg::KIND_INSERT) begin
        rsp_status_q <= full_q ? ssfl_pkg::STATUS_FULL : ssfl_pkg::STATUS_OK;
      end else if (lo_q == '0) begin
        rsp_status_q <= ssfl_pkg::STATUS_NOT_FOUND;
      end else begin
        rsp_status_q <= ssfl_pkg::STATUS_OK;
        rsp_id_q     <= id_out_ext[SidW-1:0];
        rsp_start_q  <= best_q[AdrW-1:0];
      end
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.found_id    = rsp_id_q;
  assign rsp_o.found_start = rsp_start_q;

endmodule

`default_nettype wire

[sv/ssfl_checker.sv]
// ---------------------------------------------------------------------------
// Sorted symbol floor lookup checker
// Port-level properties of the symbol table block, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module ssfl_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          req_valid_i,
  input wire logic                          req_ready_i,
  input wire logic                          rsp_valid_i,
  input wire logic                          rsp_ready_i,
  input wire logic [ssfl_pkg::STATUS_W-1:0] rsp_status_i,
  input wire logic [ssfl_pkg::SYM_ID_W-1:0] rsp_found_id_i,
  input wire logic [ssfl_pkg::ADDR_W-1:0]   rsp_found_start_i
);

  // A stalled response keeps its valid and its payload.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i)
      && $stable(rsp_found_id_i) && $stable(rsp_found_start_i))
    else $error("response changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_status_i == ssfl_pkg::STATUS_OK
      || rsp_status_i == ssfl_pkg::STATUS_NOT_FOUND
      || rsp_status_i == ssfl_pkg::STATUS_FULL)
    else $error("response status code out of range");

  // Only a successful lookup carries a symbol.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i != ssfl_pkg::STATUS_OK
      |-> rsp_found_id_i == '0 && rsp_found_start_i == '0)
    else $error("failed request returned a symbol");

  // The block works on one request at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("second request accepted while busy");

endmodule

bind sorted_symbol_floor_lookup ssfl_checker u_ssfl_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req_i.valid),
  .req_ready_i       (req_i.ready),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_status_i      (rsp_o.status),
  .rsp_found_id_i    (rsp_o.found_id),
  .rsp_found_start_i (rsp_o.found_start)
);

`default_nettype wire

[tb/tb_top.sv]
// ---------------------------------------------------------------------------
// Sorted symbol floor lookup testbench
// Sends insert and lookup requests with random gaps and response stalls,
// keeps its own sorted copy of the symbol table to predict every response,
// and checks each response field by field in order of arrival.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned SYM_DEPTH = ssfl_pkg::TABLE_DEPTH_DEF;
  localparam logic [ssfl_pkg::ADDR_W-1:0] ADDR_MAX = '1;
  localparam logic [ssfl_pkg::ADDR_W-1:0] ADDR_TOP = {1'b1, {(ssfl_pkg::ADDR_W-1){1'b0}}};

  typedef struct packed {
    ssfl_pkg::status_e               status;
    logic [ssfl_pkg::SYM_ID_W-1:0]   found_id;
    logic [ssfl_pkg::ADDR_W-1:0]     found_start;
  } sym_answer_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ssfl_req_if req_if ();
  ssfl_rsp_if rsp_if ();

  sorted_symbol_floor_lookup #(
    .TABLE_DEPTH(SYM_DEPTH),
    .ID_WIDTH   (ssfl_pkg::ID_WIDTH_DEF)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow copy of the symbol table, kept in ascending start order.
  logic [ssfl_pkg::ADDR_W-1:0]   shadow_start [SYM_DEPTH];
  logic [ssfl_pkg::SYM_ID_W-1:0] shadow_id    [SYM_DEPTH];
  int unsigned                   shadow_count = 0;

  sym_answer_t pending_answers[$];
  int          mismatch_count = 0;
  bit          calm_mode = 1'b0;

  function automatic logic [ssfl_pkg::ADDR_W-1:0] rand_addr64();
    return {$urandom, $urandom};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm_mode || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Number of stored entries whose start is not above addr.
  function automatic int unsigned entries_at_or_below(logic [ssfl_pkg::ADDR_W-1:0] addr);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = shadow_count;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (shadow_start[mid] > addr) hi = mid;
      else lo = mid + 1;
    end
    return lo;
  endfunction

  function automatic sym_answer_t predict_answer(ssfl_pkg::kind_e kind,
                                                 logic [ssfl_pkg::ADDR_W-1:0] addr,
                                                 logic [ssfl_pkg::SYM_ID_W-1:0] id);
    sym_answer_t ans;
    int unsigned pos;
    ans = '{status: ssfl_pkg::STATUS_OK, found_id: '0, found_start: '0};
    pos = entries_at_or_below(addr);
    if (kind == ssfl_pkg::KIND_INSERT) begin
      if (shadow_count >= SYM_DEPTH) begin
        ans.status = ssfl_pkg::STATUS_FULL;
      end else begin
        for (int unsigned i = shadow_count; i > pos; i--) begin
          shadow_start[i] = shadow_start[i-1];
          shadow_id[i]    = shadow_id[i-1];
        end
        shadow_start[pos] = addr;
        shadow_id[pos]    = id;
        shadow_count++;
      end
    end else if (pos == 0) begin
      ans.status = ssfl_pkg::STATUS_NOT_FOUND;
    end else begin
      ans.found_id    = shadow_id[pos-1];
      ans.found_start = shadow_start[pos-1];
    end
    return ans;
  endfunction

  task automatic send_request(ssfl_pkg::kind_e kind, logic [ssfl_pkg::ADDR_W-1:0] addr,
                              logic [ssfl_pkg::SYM_ID_W-1:0] id);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.kind        <= kind;
    req_if.sym_address <= addr;
    req_if.sym_id      <= id;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    pending_answers.push_back(predict_answer(kind, addr, id));
  endtask

  // Holds the sender off until every request has been answered.
  task automatic wait_all_answered();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_answers.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [ssfl_pkg::ADDR_W-1:0] pick_stored_start();
    return shadow_start[$urandom_range(0, shadow_count - 1)];
  endfunction

  function automatic logic [ssfl_pkg::ADDR_W-1:0] pick_insert_addr(
      logic [ssfl_pkg::ADDR_W-1:0] base);
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return base + ssfl_pkg::ADDR_W'($urandom_range(0, 255)) * 64'h100;
    if (r < 60 && shadow_count > 0) return pick_stored_start();
    if (r < 92) return rand_addr64();
    case ($urandom_range(0, 2))
      0:       return ADDR_MAX;
      1:       return ADDR_TOP;
      default: return 64'h1;
    endcase
  endfunction

  function automatic logic [ssfl_pkg::ADDR_W-1:0] pick_lookup_addr();
    int r;
    r = $urandom_range(0, 99);
    if (shadow_count > 0 && r < 35) return pick_stored_start();
    if (shadow_count > 0 && r < 60)
      return pick_stored_start() + ssfl_pkg::ADDR_W'($urandom_range(0, 255));
    if (shadow_count > 0 && r < 70) return pick_stored_start() - 64'h1;
    if (r < 90) return rand_addr64();
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return ADDR_MAX;
      default: return ADDR_TOP - 64'h1;
    endcase
  endfunction

  task automatic test_empty_and_extremes();
    send_request(ssfl_pkg::KIND_LOOKUP, '0, 16'h0000);
    send_request(ssfl_pkg::KIND_LOOKUP, ADDR_MAX, 16'hFFFF);
    send_request(ssfl_pkg::KIND_INSERT, ADDR_TOP, 16'hFFFF);
    send_request(ssfl_pkg::KIND_LOOKUP, '0, 16'h0000);
    send_request(ssfl_pkg::KIND_LOOKUP, ADDR_TOP - 64'h1, 16'h0000);
    send_request(ssfl_pkg::KIND_LOOKUP, ADDR_TOP, 16'h0000);
    send_request(ssfl_pkg::KIND_INSERT, ADDR_MAX, 16'h0000);
    send_request(ssfl_pkg::KIND_LOOKUP, ADDR_MAX, 16'h0000);
    send_request(ssfl_pkg::KIND_LOOKUP, ADDR_MAX - 64'h1, 16'h0000);
    wait_all_answered();
  endtask

  // Equal starts: the newest of the equal entries must win a lookup.
  task automatic test_equal_starts();
    calm_mode = 1'b1;
    send_request(ssfl_pkg::KIND_INSERT, 64'h1000, 16'h1234);
    send_request(ssfl_pkg::KIND_INSERT, 64'h1000, 16'h5678);
    send_request(ssfl_pkg::KIND_INSERT, 64'h1000, 16'hABCD);
    send_request(ssfl_pkg::KIND_LOOKUP, 64'h1000, 16'h0000);
    send_request(ssfl_pkg::KIND_LOOKUP, 64'h1FFF, 16'h0000);
    send_request(ssfl_pkg::KIND_LOOKUP, 64'h0FFF, 16'h0000);
    calm_mode = 1'b0;
    send_request(ssfl_pkg::KIND_INSERT, 64'h5555_5555_5555_5555, 16'h5555);
    send_request(ssfl_pkg::KIND_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 16'hAAAA);
    send_request(ssfl_pkg::KIND_LOOKUP, 64'h6000_0000_0000_0000, 16'h0000);
    send_request(ssfl_pkg::KIND_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAB, 16'h0000);
    wait_all_answered();
  endtask

  task automatic test_random_mix(int num_requests);
    logic [ssfl_pkg::ADDR_W-1:0] base;
    base = rand_addr64() & 64'hFFFF_FFFF_FFF0_0000;
    for (int n = 0; n < num_requests; n++) begin
      if (n % 100 == 0) calm_mode = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) == 0) wait_all_answered();
      if ($urandom_range(0, 1) == 0)
        send_request(ssfl_pkg::KIND_INSERT, pick_insert_addr(base),
                     ssfl_pkg::SYM_ID_W'($urandom_range(0, 65535)));
      else
        send_request(ssfl_pkg::KIND_LOOKUP, pick_lookup_addr(),
                     ssfl_pkg::SYM_ID_W'($urandom));
    end
    calm_mode = 1'b0;
    wait_all_answered();
  endtask

  // Appending at the top address keeps each insert short while the table fills.
  task automatic test_fill_to_capacity();
    send_request(ssfl_pkg::KIND_INSERT, '0, ssfl_pkg::SYM_ID_W'($urandom));
    send_request(ssfl_pkg::KIND_LOOKUP, '0, 16'h0000);
    while (shadow_count < SYM_DEPTH) begin
      if (shadow_count % 256 == 0) begin
        calm_mode = ($urandom_range(0, 1) == 1);
        send_request(ssfl_pkg::KIND_LOOKUP, ADDR_MAX, 16'h0000);
      end
      send_request(ssfl_pkg::KIND_INSERT, ADDR_MAX, ssfl_pkg::SYM_ID_W'($urandom));
    end
    calm_mode = 1'b0;
    wait_all_answered();
  endtask

  task automatic test_full_table();
    send_request(ssfl_pkg::KIND_INSERT, '0, 16'hFFFF);
    send_request(ssfl_pkg::KIND_INSERT, ADDR_MAX, 16'h0000);
    send_request(ssfl_pkg::KIND_LOOKUP, ADDR_MAX, 16'h0000);
    for (int n = 0; n < 40; n++) begin
      if ($urandom_range(0, 3) == 0)
        send_request(ssfl_pkg::KIND_INSERT, rand_addr64(), ssfl_pkg::SYM_ID_W'($urandom));
      else
        send_request(ssfl_pkg::KIND_LOOKUP, pick_lookup_addr(),
                     ssfl_pkg::SYM_ID_W'($urandom));
    end
    wait_all_answered();
  endtask

  // Response side: random stalls on ready, and an in-order check of each response.
  initial begin : response_side
    sym_answer_t want;
    int          stall;
    stall = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        if (pending_answers.size() == 0) begin
          $display("%0t: response with no request outstanding: status %0d id %h start %h",
                   $time, rsp_if.status, rsp_if.found_id, rsp_if.found_start);
          mismatch_count++;
        end else begin
          want = pending_answers.pop_front();
          if (rsp_if.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_if.status);
            mismatch_count++;
          end
          if (rsp_if.found_id !== want.found_id) begin
            $display("%0t: found_id expected %h actual %h", $time, want.found_id,
                     rsp_if.found_id);
            mismatch_count++;
          end
          if (rsp_if.found_start !== want.found_start) begin
            $display("%0t: found_start expected %h actual %h", $time, want.found_start,
                     rsp_if.found_start);
            mismatch_count++;
          end
        end
      end
      if (stall > 0) begin
        stall--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  initial begin
    rst_ni             <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.kind        <= ssfl_pkg::KIND_INSERT;
    req_if.sym_address <= '0;
    req_if.sym_id      <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_and_extremes();
    test_equal_starts();
    test_random_mix(850);
    test_fill_to_capacity();
    test_full_table();

    repeat (50) @(posedge clk_i);
    if (mismatch_count == 0 && pending_answers.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
